// ===== design/lfuc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lfuc_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_SET = 1'b1;

    typedef struct packed {
        logic                     command;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] value;
    } req_item_t;

    typedef struct packed {
        logic                     found;
        logic signed [DATA_W-1:0] read_value;
    } rsp_item_t;

    // One stored cache line: all fields written together.
    typedef struct packed {
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] value;
        logic [DATA_W-1:0]        count;
        logic [DATA_W-1:0]        stamp;
    } entry_t;

    typedef struct packed {
        logic start;
        logic read;
        logic commit;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic last_issue;
        logic is_get;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== design/lfu_cache_lru_tiebreak.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake              Payload
// req       req_valid/req_stall    req_item  (command, key, value)
// rsp       rsp_valid/rsp_stall    rsp_item  (found, read_value), one per get
// cfg       cfg_wr_en              cfg_wr_data (capacity_in_use)
//
// Each line is read from the entry memory and compared, one line a cycle,
// and the chosen line is then written back.
// Reset clears the valid bits and the access clock; line contents stay as is.
// A get waits in its last cycle while the previous result is still stalled.
// req_stall is high from accept until the item is done.

module lfu_cache_lru_tiebreak #(
    parameter int unsigned ENTRIES = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         req_valid,
    output logic                              req_stall,
    input  wire lfuc_pkg::req_item_t          req_item,
    output logic                              rsp_valid,
    input  wire logic                         rsp_stall,
    output lfuc_pkg::rsp_item_t               rsp_item,
    input  wire logic                         cfg_wr_en,
    input  wire logic [lfuc_pkg::CAP_W-1:0]   cfg_wr_data
);
    import lfuc_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    lfuc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    lfuc_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_item    (req_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp_item    (rsp_item),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

`default_nettype wire

// ===== design/lfuc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lfuc_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_stall,
    input  wire lfuc_pkg::dp_stat_t stat,
    output lfuc_pkg::dp_cmd_t     cmd
);
    import lfuc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_WRITE,
        ST_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                state_next = stat.is_get ? ST_RESP : ST_IDLE;
            end
            ST_RESP:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall  = (state_reg != ST_IDLE);
    assign cmd.start  = (state_reg == ST_IDLE) && req_valid;
    assign cmd.read   = (state_reg == ST_SCAN);
    assign cmd.commit = (state_reg == ST_WRITE);
    assign cmd.emit   = (state_reg == ST_RESP) && stat.out_free;

    a_one_commit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> !cmd.commit)
        else $error("commit repeated for one item");

    a_scan_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> cmd.read)
        else $error("scan did not begin after accept");

endmodule

`default_nettype wire

// ===== design/lfuc_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lfuc_dpath #(
    parameter int unsigned ENTRIES = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire lfuc_pkg::req_item_t req_item,
    input  wire logic                cfg_wr_en,
    input  wire logic [lfuc_pkg::CAP_W-1:0] cfg_wr_data,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output lfuc_pkg::rsp_item_t      rsp_item,
    input  wire lfuc_pkg::dp_cmd_t   cmd,
    output lfuc_pkg::dp_stat_t       stat
);
    import lfuc_pkg::*;

    localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned UW0 = $clog2(ENTRIES + 1);
    localparam int unsigned UW = (UW0 > CAP_W) ? UW0 : CAP_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);
    localparam logic [DATA_W-1:0] ONES = '1;

    entry_t mem [ENTRIES];

    logic [CAP_W-1:0]  cap_reg;
    logic [DATA_W-1:0] clock_reg;
    logic              cmd_reg;
    logic [DATA_W-1:0] key_reg;
    logic [DATA_W-1:0] value_reg;
    logic [ENTRIES-1:0] valid_reg;

    logic [AW-1:0]     addr_reg;
    logic [AW-1:0]     rd_idx_reg;
    logic              chk_reg;
    entry_t            rd_data_reg;

    logic [UW-1:0]     used_reg;
    logic              hit_reg;
    logic [AW-1:0]     hit_idx_reg;
    logic [DATA_W-1:0] hit_value_reg;
    logic [DATA_W-1:0] hit_count_reg;
    logic              free_found_reg;
    logic [AW-1:0]     free_idx_reg;
    logic              vic_found_reg;
    logic [AW-1:0]     vic_idx_reg;
    logic [DATA_W-1:0] vic_count_reg;
    logic [DATA_W-1:0] vic_stamp_reg;
    logic [DATA_W-1:0] vic_key_reg;

    logic              out_valid_reg;
    rsp_item_t         out_item_reg;

    logic              chk_vld;
    logic              chk_match;
    logic              chk_older;
    logic              full;
    logic              use_victim;
    logic              wr_en;
    logic [AW-1:0]     wr_idx;
    entry_t            wr_word;
    logic [DATA_W-1:0] hit_count_inc;

    // Compare the entry that came out of memory this cycle.
    always_comb
    begin
        chk_vld   = chk_reg && valid_reg[rd_idx_reg];
        chk_match = chk_vld && (rd_data_reg.key == key_reg);
        if (rd_data_reg.count != vic_count_reg)
        begin
            chk_older = rd_data_reg.count < vic_count_reg;
        end
        else if (rd_data_reg.stamp != vic_stamp_reg)
        begin
            chk_older = rd_data_reg.stamp < vic_stamp_reg;
        end
        else
        begin
            chk_older = $signed(rd_data_reg.key) < $signed(vic_key_reg);
        end
    end

    assign full          = used_reg >= UW'(cap_reg);
    assign use_victim    = full || !free_found_reg;
    assign hit_count_inc = (hit_count_reg == ONES) ? hit_count_reg : hit_count_reg + 1'b1;

    // Choose the line to write once the scan is over.
    always_comb
    begin
        wr_en         = 1'b0;
        wr_idx        = free_idx_reg;
        wr_word.key   = key_reg;
        wr_word.value = value_reg;
        wr_word.count = DATA_W'(1);
        wr_word.stamp = clock_reg;
        if (hit_reg)
        begin
            wr_en         = 1'b1;
            wr_idx        = hit_idx_reg;
            wr_word.value = (cmd_reg == CMD_SET) ? value_reg : hit_value_reg;
            wr_word.count = hit_count_inc;
        end
        else if ((cmd_reg == CMD_SET) && (cap_reg != '0))
        begin
            if (use_victim)
            begin
                wr_en  = vic_found_reg;
                wr_idx = vic_idx_reg;
            end
            else
            begin
                wr_en = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && wr_en)
        begin
            mem[wr_idx] <= wr_word;
        end
        if (cmd.read)
        begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            cmd_reg   <= req_item.command;
            key_reg   <= req_item.key;
            value_reg <= req_item.value;
        end
        if (cmd.read)
        begin
            rd_idx_reg <= addr_reg;
        end
        if (chk_match && !hit_reg)
        begin
            hit_idx_reg   <= rd_idx_reg;
            hit_value_reg <= rd_data_reg.value;
            hit_count_reg <= rd_data_reg.count;
        end
        if (chk_reg && !valid_reg[rd_idx_reg] && !free_found_reg)
        begin
            free_idx_reg <= rd_idx_reg;
        end
        if (chk_vld && (!vic_found_reg || chk_older))
        begin
            vic_idx_reg   <= rd_idx_reg;
            vic_count_reg <= rd_data_reg.count;
            vic_stamp_reg <= rd_data_reg.stamp;
            vic_key_reg   <= rd_data_reg.key;
        end
        if (cmd.emit)
        begin
            out_item_reg.found      <= hit_reg;
            out_item_reg.read_value <= hit_reg ? hit_value_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg        <= CAP_RESET;
            clock_reg      <= '0;
            valid_reg      <= '0;
            addr_reg       <= '0;
            chk_reg        <= 1'b0;
            used_reg       <= '0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            vic_found_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
            chk_reg <= cmd.read;
            if (cmd.start)
            begin
                if (clock_reg != ONES)
                begin
                    clock_reg <= clock_reg + 1'b1;
                end
                addr_reg       <= '0;
                used_reg       <= '0;
                hit_reg        <= 1'b0;
                free_found_reg <= 1'b0;
                vic_found_reg  <= 1'b0;
            end
            else if (cmd.read)
            begin
                addr_reg <= addr_reg + 1'b1;
            end
            if (chk_vld)
            begin
                used_reg      <= used_reg + 1'b1;
                vic_found_reg <= 1'b1;
            end
            if (chk_match)
            begin
                hit_reg <= 1'b1;
            end
            if (chk_reg && !valid_reg[rd_idx_reg])
            begin
                free_found_reg <= 1'b1;
            end
            if (cmd.commit && wr_en)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.last_issue = cmd.read && (addr_reg == LAST_IDX);
    assign stat.is_get     = (cmd_reg == CMD_GET);
    assign stat.out_free   = !out_valid_reg || !rsp_stall;

    assign rsp_valid = out_valid_reg;
    assign rsp_item  = out_item_reg;

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("result loaded over an untaken item");

    a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && hit_reg) |-> valid_reg[hit_idx_reg])
        else $error("hit on an empty line");

    a_clock_step: assert property (@(posedge clk) disable iff (!rst_n)
        (clock_reg != $past(clock_reg)) |-> (clock_reg == DATA_W'($past(clock_reg) + 1'b1)))
        else $error("access clock jumped");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= UW'(ENTRIES))
        else $error("occupancy count out of range");

endmodule

`default_nettype wire
